>>> hw/rtl/bqf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_pkg: shared types and constants of the biquad filter
// Sample and coefficient formats, register indexes, payload structs and
// the tag that travels with each item from the front end to the back end.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // sample format, signed Q1.15
  localparam int unsigned SAMPLE_WIDTH  = 16;
  // default coefficient width, signed Q3.28 (sign plus three integer bits)
  localparam int unsigned COEF_WIDTH    = 32;
  localparam int unsigned COEF_INT_BITS = 4;
  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned CFG_IDX_WIDTH = 3;
  // accumulator wraps at 64 bits for very wide formats
  localparam int unsigned ACC_MAX_WIDTH = 64;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_COEF_B0       = 3'd0,
    REG_COEF_B1       = 3'd1,
    REG_COEF_B2       = 3'd2,
    REG_COEF_A1       = 3'd3,
    REG_COEF_A2       = 3'd4,
    REG_FILTER_ENABLE = 3'd5
  } reg_idx_e;

  typedef enum logic {
    CMD_FILTER  = 1'b0,
    CMD_PRELOAD = 1'b1
  } command_e;

  // what the back end has to do with a queued item
  typedef enum logic [1:0] {
    KIND_FILTER  = 2'd0,
    KIND_BYPASS  = 2'd1,
    KIND_PRELOAD = 2'd2
  } kind_e;

  typedef struct packed {
    command_e                       command;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
    logic                           saturated;
  } out_item_t;

  typedef struct packed {
    kind_e                          kind;
    logic signed [SAMPLE_WIDTH-1:0] value;
  } item_tag_t;

  // saturation bounds, sign-extended to the compare width
  localparam logic signed [63:0] SAT_HI = {{(64-SAMPLE_WIDTH+1){1'b0}},
                                           {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [63:0] SAT_LO = ~SAT_HI;

  // full-precision sum of five products, capped at the wrap width
  function automatic int unsigned acc_width(int unsigned coef_w);
    int unsigned full_w;
    full_w = SAMPLE_WIDTH + coef_w + 3;
    return (full_w > ACC_MAX_WIDTH) ? ACC_MAX_WIDTH : full_w;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bqf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_fifo: small register queue
// Decouples the feedforward front end from the recursive back end. The
// writer never pushes into a full queue; it tracks space by credits.
// ----------------------------------------------------------------------------
module bqf_fifo #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = bqf_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  valid_o,
  output logic      [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bqf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_front: input stage and feedforward products
// Accepts beats, classifies them, keeps the input history and forms
// b0*x + b1*x1 + b2*x2 in two registered steps before queueing the item.
// ----------------------------------------------------------------------------
module bqf_front #(
  parameter  int unsigned COEF_WIDTH = bqf_pkg::COEF_WIDTH,
  localparam int unsigned ACC_W      = bqf_pkg::acc_width(COEF_WIDTH),
  localparam int unsigned CNT_W      = $clog2(bqf_pkg::QUEUE_DEPTH + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire bqf_pkg::in_item_t            in_data_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b0_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b1_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b2_i,
  input  wire logic                         filter_enable_i,
  input  wire logic        [CNT_W-1:0]      queue_count_i,
  output logic             [1:0]            inflight_o,
  output logic                              push_o,
  output bqf_pkg::item_tag_t                push_tag_o,
  output logic signed      [ACC_W-1:0]      push_ff_o
);

  localparam int unsigned SW     = bqf_pkg::SAMPLE_WIDTH;
  localparam int unsigned PROD_W = COEF_WIDTH + SW;
  localparam int unsigned OCC_W  = CNT_W + 1;

  logic                    accept;
  logic [OCC_W-1:0]        occupancy;
  logic signed [SW-1:0]    x1_q, x2_q;
  bqf_pkg::item_tag_t      tag_in;
  logic                    va_q, vb_q;
  bqf_pkg::item_tag_t      tag_a_q, tag_b_q;
  logic signed [SW-1:0]    x1_a_q, x2_a_q;
  logic signed [PROD_W-1:0] pb0_q, pb1_q, pb2_q;

  // credit check: queue entries plus items still in the two stages
  assign occupancy  = OCC_W'(queue_count_i) + OCC_W'(va_q) + OCC_W'(vb_q);
  assign in_stall_o = (occupancy >= OCC_W'(bqf_pkg::QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign inflight_o = 2'(va_q) + 2'(vb_q);

  // classify the beat
  always_comb begin
    tag_in.value = in_data_i.sample_value;
    if (in_data_i.command == bqf_pkg::CMD_PRELOAD) begin
      tag_in.kind = bqf_pkg::KIND_PRELOAD;
    end else if (filter_enable_i) begin
      tag_in.kind = bqf_pkg::KIND_FILTER;
    end else begin
      tag_in.kind = bqf_pkg::KIND_BYPASS;
    end
  end

  // input history and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= accept;
      vb_q <= va_q;
      if (accept) begin
        case (tag_in.kind)
          bqf_pkg::KIND_PRELOAD: begin
            x1_q <= tag_in.value;
            x2_q <= tag_in.value;
          end
          bqf_pkg::KIND_FILTER: begin
            x1_q <= tag_in.value;
            x2_q <= x1_q;
          end
          default: ;
        endcase
      end
    end
  end

  // stage a: snapshot of sample and history
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_a_q <= tag_in;
      x1_a_q  <= x1_q;
      x2_a_q  <= x2_q;
    end
  end

  // stage b: three feedforward products
  always_ff @(posedge clk_i) begin
    tag_b_q <= tag_a_q;
    pb0_q   <= PROD_W'(coef_b0_i) * PROD_W'(tag_a_q.value);
    pb1_q   <= PROD_W'(coef_b1_i) * PROD_W'(x1_a_q);
    pb2_q   <= PROD_W'(coef_b2_i) * PROD_W'(x2_a_q);
  end

  // feedforward sum goes into the queue
  assign push_o     = vb_q;
  assign push_tag_o = tag_b_q;
  assign push_ff_o  = ACC_W'(pb0_q) + ACC_W'(pb1_q) + ACC_W'(pb2_q);

endmodule
`default_nettype wire

>>> hw/rtl/bqf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_back: feedback, rounding and saturation
// Pops queued items, closes the output recursion with one a1*y1 multiply
// per item (a2*y2 is prepared ahead in a register) and holds the output register.
// ----------------------------------------------------------------------------
module bqf_back #(
  parameter  int unsigned COEF_WIDTH = bqf_pkg::COEF_WIDTH,
  localparam int unsigned ACC_W      = bqf_pkg::acc_width(COEF_WIDTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         head_valid_i,
  input  wire bqf_pkg::item_tag_t           head_tag_i,
  input  wire logic signed [ACC_W-1:0]      head_ff_i,
  output logic                              pop_o,
  input  wire logic signed [COEF_WIDTH-1:0] coef_a1_i,
  input  wire logic signed [COEF_WIDTH-1:0] coef_a2_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output bqf_pkg::out_item_t                out_data_o
);

  localparam int unsigned SW     = bqf_pkg::SAMPLE_WIDTH;
  localparam int unsigned PROD_W = COEF_WIDTH + SW;
  localparam int unsigned FRAC_W = COEF_WIDTH - bqf_pkg::COEF_INT_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  logic signed [SW-1:0]     y1_q, y1_d, y2_q, y2_d;
  logic signed [PROD_W-1:0] p2_q, p1;
  logic signed [ACC_W-1:0]  acc;
  logic signed [63:0]       res64;
  logic                     sat_hi, sat_lo;
  logic signed [SW-1:0]     y_new;
  logic                     out_valid_q, out_valid_d;
  bqf_pkg::out_item_t       out_data_q, out_data_d;

  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  // recursion: ff - a1*y1 - a2*y2, round half up, saturate
  assign p1     = PROD_W'(coef_a1_i) * PROD_W'(y1_q);
  assign acc    = head_ff_i - ACC_W'(p1) - ACC_W'(p2_q) + ROUND_HALF;
  assign res64  = 64'($signed(acc[ACC_W-1:FRAC_W]));
  assign sat_hi = (res64 > bqf_pkg::SAT_HI);
  assign sat_lo = (res64 < bqf_pkg::SAT_LO);
  assign y_new  = sat_hi ? bqf_pkg::SAT_HI[SW-1:0] :
                  sat_lo ? bqf_pkg::SAT_LO[SW-1:0] : res64[SW-1:0];

  // history and output register next values
  always_comb begin
    y1_d        = y1_q;
    y2_d        = y2_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      case (head_tag_i.kind)
        bqf_pkg::KIND_FILTER: begin
          y1_d                       = y_new;
          y2_d                       = y1_q;
          out_valid_d                = 1'b1;
          out_data_d.filtered_sample = y_new;
          out_data_d.saturated       = sat_hi || sat_lo;
        end
        bqf_pkg::KIND_BYPASS: begin
          out_valid_d                = 1'b1;
          out_data_d.filtered_sample = head_tag_i.value;
          out_data_d.saturated       = 1'b0;
        end
        bqf_pkg::KIND_PRELOAD: begin
          y1_d = head_tag_i.value;
          y2_d = head_tag_i.value;
        end
        default: ;
      endcase
    end
  end

  // a2*y2 for the next item is formed while this one is delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q        <= '0;
      y2_q        <= '0;
      p2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      y1_q        <= y1_d;
      y2_q        <= y2_d;
      p2_q        <= PROD_W'(coef_a2_i) * PROD_W'(y2_d);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

>>> hw/rtl/biquad_iir_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_iir_filter: direct form I second-order IIR section
// Filters signed samples with Q3.28 coefficients, rounds and saturates the
// full-width sum, passes samples through when disabled, and preloads the
// history on command.
//
//   channel  direction  signals                          beat when
//   in       sink       in_valid_i in_stall_o in_data_i  valid && !stall
//   out      source     out_valid_o out_stall_i out_data_o valid && !stall
//   cfg      sink       cfg_we_i cfg_idx_i cfg_data_i    cfg_we_i
//
// One beat per cycle sustained while out_stall_i stays low; a taken sample passes
// the two front stages, the queue and the output register in that order.
// The output recursion closes combinationally around the y1 history register
// in the back end: one a1*y1 multiply, the accumulate, rounding and saturation.
// Reset clears coefficients, enable and all history to zero; no clearing pass.
// Output stalls fill the four-entry queue; in_stall_o rises once queue entries plus front items reach four.
// ----------------------------------------------------------------------------
module biquad_iir_filter #(
  parameter  int unsigned COEF_WIDTH = bqf_pkg::COEF_WIDTH,
  localparam int unsigned ACC_W      = bqf_pkg::acc_width(COEF_WIDTH)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire bqf_pkg::in_item_t                    in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output bqf_pkg::out_item_t                        out_data_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bqf_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  wire logic [COEF_WIDTH-1:0]                cfg_data_i
);

  localparam int unsigned CNT_W   = $clog2(bqf_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = $bits(bqf_pkg::item_tag_t) + ACC_W;

  logic signed [COEF_WIDTH-1:0] coef_b0_q, coef_b1_q, coef_b2_q;
  logic signed [COEF_WIDTH-1:0] coef_a1_q, coef_a2_q;
  logic                         filter_enable_q;

  logic                         push;
  bqf_pkg::item_tag_t           push_tag;
  logic signed [ACC_W-1:0]      push_ff;
  logic [CNT_W-1:0]             queue_count;
  logic [1:0]                   inflight;
  logic [ENTRY_W-1:0]           head_entry;
  logic                         head_valid;
  logic                         pop;
  bqf_pkg::item_tag_t           head_tag;
  logic signed [ACC_W-1:0]      head_ff;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q       <= '0;
      coef_b1_q       <= '0;
      coef_b2_q       <= '0;
      coef_a1_q       <= '0;
      coef_a2_q       <= '0;
      filter_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (bqf_pkg::reg_idx_e'(cfg_idx_i))
        bqf_pkg::REG_COEF_B0:       coef_b0_q       <= cfg_data_i;
        bqf_pkg::REG_COEF_B1:       coef_b1_q       <= cfg_data_i;
        bqf_pkg::REG_COEF_B2:       coef_b2_q       <= cfg_data_i;
        bqf_pkg::REG_COEF_A1:       coef_a1_q       <= cfg_data_i;
        bqf_pkg::REG_COEF_A2:       coef_a2_q       <= cfg_data_i;
        bqf_pkg::REG_FILTER_ENABLE: filter_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front end: accept, classify, feedforward
  bqf_front #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_data_i       (in_data_i),
    .coef_b0_i       (coef_b0_q),
    .coef_b1_i       (coef_b1_q),
    .coef_b2_i       (coef_b2_q),
    .filter_enable_i (filter_enable_q),
    .queue_count_i   (queue_count),
    .inflight_o      (inflight),
    .push_o          (push),
    .push_tag_o      (push_tag),
    .push_ff_o       (push_ff)
  );

  // queue between the two halves
  bqf_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (bqf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_tag, push_ff}),
    .pop_i   (pop),
    .data_o  (head_entry),
    .valid_o (head_valid),
    .count_o (queue_count)
  );

  assign head_tag = head_entry[ENTRY_W-1:ACC_W];
  assign head_ff  = head_entry[ACC_W-1:0];

  // back end: feedback and output register
  bqf_back #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_tag_i   (head_tag),
    .head_ff_i    (head_ff),
    .pop_o        (pop),
    .coef_a1_i    (coef_a1_q),
    .coef_a2_i    (coef_a2_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // credits never overcommit the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W + 2)'(queue_count) + (CNT_W + 2)'(inflight) <=
      (CNT_W + 2)'(bqf_pkg::QUEUE_DEPTH))
    else $error("queue credits overcommitted");

  // no push into a full queue unless an entry leaves in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && queue_count == CNT_W'(bqf_pkg::QUEUE_DEPTH)) |-> pop)
    else $error("push into full queue");

  // a pop only takes a real entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // a preload leaves no result behind: output stays idle if it was idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_tag.kind == bqf_pkg::KIND_PRELOAD && !out_valid_o) |=> !out_valid_o)
    else $error("preload produced a result");

endmodule
`default_nettype wire

>>> bench/biquad_iir_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_checker: result prediction and comparison for the biquad
// Watches the input, output and register write ports of the filter, keeps
// its own copy of the coefficients and the four history samples, predicts
// each output beat and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module biquad_iir_filter_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  bqf_pkg::in_item_t                 in_data_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  bqf_pkg::out_item_t                out_data_i,
  input  logic                              cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [bqf_pkg::COEF_WIDTH-1:0]    cfg_data_i,
  output int                                mismatch_count_o,
  output int                                pending_count_o
);

  localparam int unsigned FRAC_BITS  = bqf_pkg::COEF_WIDTH - bqf_pkg::COEF_INT_BITS;
  localparam longint      SAMPLE_MAX = (longint'(1) <<< (bqf_pkg::SAMPLE_WIDTH - 1)) - 1;
  localparam longint      SAMPLE_MIN = -SAMPLE_MAX - 1;

  // shadow coefficients and enable
  logic signed [bqf_pkg::COEF_WIDTH-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic                                    filter_on;

  // shadow history
  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] x_d1, x_d2, y_d1, y_d2;

  bqf_pkg::out_item_t expected_outputs[$];
  bqf_pkg::out_item_t predicted, oldest;

  // one direct form I step; returns 1 when the beat produces an output
  function automatic bit predict_biquad(input bqf_pkg::in_item_t beat,
                                        output bqf_pkg::out_item_t res);
    longint acc;
    longint scaled;
    res = '0;
    if (beat.command == bqf_pkg::CMD_PRELOAD) begin
      x_d1 = beat.sample_value;
      x_d2 = beat.sample_value;
      y_d1 = beat.sample_value;
      y_d2 = beat.sample_value;
      return 1'b0;
    end
    if (!filter_on) begin
      res.filtered_sample = beat.sample_value;
      res.saturated       = 1'b0;
      return 1'b1;
    end
    acc = longint'(coef_b0) * longint'(beat.sample_value)
        + longint'(coef_b1) * longint'(x_d1)
        + longint'(coef_b2) * longint'(x_d2)
        - longint'(coef_a1) * longint'(y_d1)
        - longint'(coef_a2) * longint'(y_d2);
    // round half up, then back to sample scale
    scaled = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.saturated = 1'b1;
    if (scaled > SAMPLE_MAX) begin
      scaled = SAMPLE_MAX;
    end else if (scaled < SAMPLE_MIN) begin
      scaled = SAMPLE_MIN;
    end else begin
      res.saturated = 1'b0;
    end
    res.filtered_sample = scaled[bqf_pkg::SAMPLE_WIDTH-1:0];
    x_d2 = x_d1;
    x_d1 = beat.sample_value;
    y_d2 = y_d1;
    y_d1 = res.filtered_sample;
    return 1'b1;
  endfunction

  // observe all three ports on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0 = '0;
      coef_b1 = '0;
      coef_b2 = '0;
      coef_a1 = '0;
      coef_a2 = '0;
      filter_on = 1'b0;
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
      expected_outputs.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      // output beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected output beat: filtered_sample %0d saturated %0d",
                 out_data_i.filtered_sample, out_data_i.saturated);
          mismatch_count_o++;
        end else begin
          oldest = expected_outputs.pop_front();
          if (out_data_i.filtered_sample !== oldest.filtered_sample) begin
            $error("filtered_sample: expected %0d, actual %0d",
                   oldest.filtered_sample, out_data_i.filtered_sample);
            mismatch_count_o++;
          end
          if (out_data_i.saturated !== oldest.saturated) begin
            $error("saturated: expected %0d, actual %0d",
                   oldest.saturated, out_data_i.saturated);
            mismatch_count_o++;
          end
        end
      end
      // register writes, unused indexes fall through
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bqf_pkg::REG_COEF_B0:       coef_b0 = cfg_data_i;
          bqf_pkg::REG_COEF_B1:       coef_b1 = cfg_data_i;
          bqf_pkg::REG_COEF_B2:       coef_b2 = cfg_data_i;
          bqf_pkg::REG_COEF_A1:       coef_a1 = cfg_data_i;
          bqf_pkg::REG_COEF_A2:       coef_a2 = cfg_data_i;
          bqf_pkg::REG_FILTER_ENABLE: filter_on = cfg_data_i[0];
          default: ;
        endcase
      end
      // input beat
      if (in_valid_i && !in_stall_i) begin
        if (predict_biquad(in_data_i, predicted)) begin
          expected_outputs.push_back(predicted);
        end
      end
      pending_count_o = expected_outputs.size();
    end
  end

endmodule

>>> bench/biquad_iir_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_tb: stimulus and verdict for the biquad filter
// Runs a short directed pass over bypass, preload, saturation and rounding,
// then random phases under changing coefficient sets with random idle beats
// on both channels and one long output hold-off. The checker beside the
// block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module biquad_iir_filter_tb;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_CYCLES     = 48;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int BYPASS_PHASE    = 2;
  localparam int HOLD_PHASE      = 3;
  localparam int FULL_PHASE      = 5;
  localparam int EXTREME_PHASE   = 6;

  // indexes that decode to no register
  localparam logic [bqf_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bqf_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

  // coefficient styles
  localparam int STYLE_MILD    = 0;
  localparam int STYLE_FULL    = 1;
  localparam int STYLE_EXTREME = 2;

  localparam logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] SMP_MIN = 16'sh8000;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  bqf_pkg::in_item_t                 in_data_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  bqf_pkg::out_item_t                out_data_o;
  logic                              cfg_we_i;
  logic [bqf_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [bqf_pkg::COEF_WIDTH-1:0]    cfg_data_i;

  int mismatch_count;
  int pending_count;
  int idle_cycles = 0;
  bit quiet;
  bit hold_request;

  biquad_iir_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  biquad_iir_filter_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // clock
  always #CLK_HALF clk_i = ~clk_i;

  // watchdog on cycles without any beat or register write
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // offer one beat, entered and left on a falling edge
  task automatic send_beat(input bqf_pkg::command_e cmd,
                           input logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] value);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_data_i.command      <= cmd;
    in_data_i.sample_value <= value;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [bqf_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [bqf_pkg::COEF_WIDTH-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for every predicted beat, then let the pipe drain with the input idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] random_sample();
    int s;
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2, 3: begin
        s = $urandom_range(0, 512) - 256;
        return s[bqf_pkg::SAMPLE_WIDTH-1:0];
      end
      default: return bqf_pkg::SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [bqf_pkg::COEF_WIDTH-1:0] pick_coef(input int phase);
    int style;
    int c;
    if (phase == FULL_PHASE) style = STYLE_FULL;
    else if (phase == EXTREME_PHASE) style = STYLE_EXTREME;
    else if (phase == 1 || phase == 4) style = $urandom_range(STYLE_MILD, STYLE_EXTREME);
    else style = STYLE_MILD;
    case (style)
      STYLE_FULL: return $urandom();
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'h1000_0000;
        endcase
      end
      default: begin
        // within +-0.5 so the section mostly stays in range
        c = $urandom_range(0, 2 ** 28) - 2 ** 27;
        return c;
      end
    endcase
  endfunction

  initial begin
    logic [bqf_pkg::COEF_WIDTH-1:0] enable_word;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bypass after reset, preload while disabled
    send_beat(bqf_pkg::CMD_FILTER, SMP_MAX);
    send_beat(bqf_pkg::CMD_FILTER, SMP_MIN);
    send_beat(bqf_pkg::CMD_FILTER, 16'sd0);
    send_beat(bqf_pkg::CMD_PRELOAD, SMP_MIN);
    send_beat(bqf_pkg::CMD_FILTER, 16'sh5555);
    settle();

    // extreme coefficients, saturation both ways
    write_reg(bqf_pkg::REG_COEF_B0, 32'h7fff_ffff);
    write_reg(bqf_pkg::REG_COEF_B1, 32'h0000_0000);
    write_reg(bqf_pkg::REG_COEF_B2, 32'h0000_0000);
    write_reg(bqf_pkg::REG_COEF_A1, 32'h8000_0000);
    write_reg(bqf_pkg::REG_COEF_A2, 32'h0000_0000);
    write_reg(bqf_pkg::REG_FILTER_ENABLE, 32'hffff_ffff);
    send_beat(bqf_pkg::CMD_FILTER, SMP_MAX);
    send_beat(bqf_pkg::CMD_PRELOAD, 16'sd0);
    send_beat(bqf_pkg::CMD_FILTER, SMP_MAX);
    send_beat(bqf_pkg::CMD_FILTER, SMP_MIN);
    send_beat(bqf_pkg::CMD_PRELOAD, 16'sd0);
    send_beat(bqf_pkg::CMD_FILTER, SMP_MIN);
    send_beat(bqf_pkg::CMD_PRELOAD, SMP_MAX);
    send_beat(bqf_pkg::CMD_FILTER, -16'sd1);
    settle();

    // gain of one half, rounding of exact halves
    write_reg(bqf_pkg::REG_COEF_B0, 32'h0800_0000);
    write_reg(bqf_pkg::REG_COEF_A1, 32'h0000_0000);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    send_beat(bqf_pkg::CMD_FILTER, 16'sd1);
    send_beat(bqf_pkg::CMD_FILTER, -16'sd1);
    send_beat(bqf_pkg::CMD_FILTER, 16'sd3);
    send_beat(bqf_pkg::CMD_FILTER, -16'sd3);
    send_beat(bqf_pkg::CMD_FILTER, SMP_MAX);
    send_beat(bqf_pkg::CMD_FILTER, SMP_MIN);

    // random phases, each under a fresh register set
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      quiet = (phase == RANDOM_PHASES - 1);
      write_reg(bqf_pkg::REG_COEF_B0, pick_coef(phase));
      write_reg(bqf_pkg::REG_COEF_B1, pick_coef(phase));
      write_reg(bqf_pkg::REG_COEF_B2, pick_coef(phase));
      write_reg(bqf_pkg::REG_COEF_A1, pick_coef(phase));
      write_reg(bqf_pkg::REG_COEF_A2, pick_coef(phase));
      enable_word    = $urandom();
      enable_word[0] = (phase != BYPASS_PHASE);
      write_reg(bqf_pkg::REG_FILTER_ENABLE, enable_word);
      if (phase == HOLD_PHASE) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        send_beat(($urandom_range(0, 9) == 0) ? bqf_pkg::CMD_PRELOAD : bqf_pkg::CMD_FILTER,
                  random_sample());
      end
    end
    settle();

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
